// ===== rtl/core/cmpatt_pkg.sv =====
// Shared constants, codes and helper functions of the complementary attitude filter.
`timescale 1ns / 1ps

package cmpatt_pkg;

    localparam int ANG_W        = 20;
    localparam int ACC_W        = 16;
    localparam int RATE_W       = 24;
    localparam int DT_W         = 24;
    localparam int WEIGHT_W     = 16;
    localparam int GAIN_W       = 24;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_ADDR_W   = 1;
    localparam int S_TDATA_W    = 144;
    localparam int M_TDATA_W    = 104;
    localparam int TABLE_LEN    = 24;
    localparam int ITER_W       = 5;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam int ANG_MAX      = 524287;
    localparam int ANG_MIN      = -524288;
    localparam int Q16_PI       = 205887;
    localparam int Q16_HALF_PI  = 102944;
    localparam int Q16_TWO_PI   = 411775;
    localparam int Q24_GAIN     = 10188014;

    localparam int WEIGHT_RESET = 655;
    localparam int GAIN_RESET   = 3355;

    localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING_WEIGHT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CORRECTION_GAIN  = 1'b1;

    // Arctangent of 2^-i in Q3.16, rounded; entries from 17 on are zero.
    function automatic logic signed [20:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic signed [20:0] v;
        unique case (idx)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

    // Clamp a wide angle sum to the 20-bit angle range.
    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [29:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > 30'sd524287) begin
            r = 20'sd524287;
        end else if (v < -30'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/complementary_attitude_filter.sv =====
// Top level of the complementary attitude filter: sequencer, shared CORDIC and multiplier.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_*       in         tdata: accel x/y/z, gyro roll/pitch/yaw, time step; tuser: seed
// m_*       out        tdata: roll, pitch, yaw, smoothed accel roll, smoothed accel pitch
// cfg_*     in         register write: index 0 smoothing weight, 1 correction gain
//
// One item passes in turn through the single shift-add CORDIC unit
// that serves both arctangents and the sine/cosine, and through the one
// 27x27 multiplier that serves every product in turn. A seed item skips the
// multiplies. s_tready is high only while idle; a finished result waits in
// the output register, so the next input transfer is taken while it stalls.
// aresetn is synchronous; it clears the state angles and loads register defaults.
module complementary_attitude_filter
    import cmpatt_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = cmpatt_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // accel_x, accel_y, accel_z, gyro_roll, gyro_pitch, gyro_yaw, time_step
    input  logic [cmpatt_pkg::S_TDATA_W-1:0]    s_tdata,
    // seed
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // roll_out, pitch_out, yaw_out, acc_roll_out, acc_pitch_out, zero pad
    output logic [cmpatt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [cmpatt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cmpatt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int NITER = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
    localparam logic signed [53:0] RND16 = 54'sd32768;
    localparam logic signed [53:0] RND24 = 54'sd8388608;

    typedef enum logic [2:0] {
        ST_IDLE, ST_VSET, ST_SSET, ST_CORD, ST_CSTORE, ST_MUL, ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        JOB_ROLL, JOB_PITCH, JOB_SC
    } job_t;

    state_t state_reg;
    job_t   job_reg;

    logic [WEIGHT_W-1:0] weight_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // captured item
    logic signed [ACC_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [RATE_W-1:0] gr_reg, gp_reg, gy_reg;
    logic [DT_W-1:0]          dt_reg;
    logic                     seed_reg;

    // filter state
    logic signed [ANG_W-1:0] filt_roll_reg, filt_pitch_reg;
    logic signed [ANG_W-1:0] est_roll_reg, est_pitch_reg, est_yaw_reg;
    logic signed [ANG_W-1:0] acc_roll_reg, acc_pitch_reg;

    // CORDIC unit
    logic signed [27:0]       cx_reg, cy_reg;
    logic signed [20:0]       cz_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic                     zero_reg, neg_reg;
    logic signed [26:0]       c_reg, s_reg;

    // multiplier and accumulator
    logic [3:0]               step_reg;
    logic                     phase_reg;
    logic signed [53:0]       prod_reg, acc_reg;
    logic signed [26:0]       rate_reg;
    logic signed [29:0]       tmp_reg;

    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // vector for the arctangent pass: roll uses (-az, -ay), pitch (-az, ax)
    logic signed [16:0] vx, vy;
    always_comb begin
        vx = -17'(az_reg);
        vy = (job_reg == JOB_ROLL) ? -17'(ay_reg) : 17'(ax_reg);
    end

    // reduce the pitch into the right half plane for sine/cosine
    logic signed [21:0] sz_wrap, sz_fold;
    logic               s_neg;
    always_comb begin
        sz_wrap = 22'(est_pitch_reg);
        if (sz_wrap > Q16_PI) begin
            sz_wrap = 22'(sz_wrap - Q16_TWO_PI);
        end else if (sz_wrap < -Q16_PI) begin
            sz_wrap = 22'(sz_wrap + Q16_TWO_PI);
        end
        sz_fold = sz_wrap;
        s_neg   = 1'b0;
        if (sz_wrap > Q16_HALF_PI) begin
            sz_fold = 22'(sz_wrap - Q16_PI);
            s_neg   = 1'b1;
        end else if (sz_wrap < -Q16_HALF_PI) begin
            sz_fold = 22'(sz_wrap + Q16_PI);
            s_neg   = 1'b1;
        end
    end

    // one CORDIC micro-rotation; vectoring drives y to zero, rotation drives z
    logic signed [27:0] xs, ys;
    logic               c_sel;
    logic signed [27:0] cx_next, cy_next;
    logic signed [20:0] cz_next;
    always_comb begin
        xs    = cx_reg >>> iter_reg;
        ys    = cy_reg >>> iter_reg;
        c_sel = (job_reg != JOB_SC) ? !cy_reg[27] : cz_reg[20];
        if (c_sel) begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + atan_q16(iter_reg);
        end else begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - atan_q16(iter_reg);
        end
    end

    // multiplier operand select
    logic signed [26:0] mul_a, mul_b;
    logic signed [20:0] d_fr, d_fp, d_er, d_ep;
    always_comb begin
        d_fr = 21'(acc_roll_reg) - 21'(filt_roll_reg);
        d_fp = 21'(acc_pitch_reg) - 21'(filt_pitch_reg);
        d_er = 21'(filt_roll_reg) - 21'(est_roll_reg);
        d_ep = 21'(filt_pitch_reg) - 21'(est_pitch_reg);
        unique case (step_reg)
            4'd0:    begin mul_a = 27'(d_fr);   mul_b = 27'({1'b0, weight_reg}); end
            4'd1:    begin mul_a = 27'(d_fp);   mul_b = 27'({1'b0, weight_reg}); end
            4'd2:    begin mul_a = 27'(gp_reg); mul_b = 27'({1'b0, dt_reg}); end
            4'd3:    begin mul_a = 27'(d_ep);   mul_b = 27'({1'b0, gain_reg}); end
            4'd4:    begin mul_a = 27'(gr_reg); mul_b = c_reg; end
            4'd5:    begin mul_a = 27'(gy_reg); mul_b = s_reg; end
            4'd6:    begin mul_a = rate_reg;    mul_b = 27'({1'b0, dt_reg}); end
            4'd7:    begin mul_a = 27'(d_er);   mul_b = 27'({1'b0, gain_reg}); end
            4'd8:    begin mul_a = 27'(gy_reg); mul_b = c_reg; end
            4'd9:    begin mul_a = 27'(gr_reg); mul_b = s_reg; end
            default: begin mul_a = rate_reg;    mul_b = 27'({1'b0, dt_reg}); end
        endcase
    end

    // rounded forms of the registered product
    logic signed [53:0] r16_full, r24_full, rsum_full, rdiff_full;
    logic signed [29:0] r16, r24;
    always_comb begin
        r16_full   = (prod_reg + RND16) >>> 16;
        r24_full   = (prod_reg + RND24) >>> 24;
        rsum_full  = (acc_reg + prod_reg + RND24) >>> 24;
        rdiff_full = (acc_reg - prod_reg + RND24) >>> 24;
        r16        = r16_full[29:0];
        r24        = r24_full[29:0];
    end

    logic out_free;
    logic load_out;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ST_FIN) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            job_reg        <= JOB_ROLL;
            weight_reg     <= WEIGHT_W'(WEIGHT_RESET);
            gain_reg       <= GAIN_W'(GAIN_RESET);
            filt_roll_reg  <= '0;
            filt_pitch_reg <= '0;
            est_roll_reg   <= '0;
            est_pitch_reg  <= '0;
            est_yaw_reg    <= '0;
            iter_reg       <= '0;
            step_reg       <= '0;
            phase_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SMOOTHING_WEIGHT: weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                    CFG_CORRECTION_GAIN:  gain_reg   <= cfg_wdata[GAIN_W-1:0];
                    default:              ;
                endcase
            end

            // raise valid on a new result, drop it once the transfer is taken
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ax_reg    <= s_tdata[15:0];
                        ay_reg    <= s_tdata[31:16];
                        az_reg    <= s_tdata[47:32];
                        gr_reg    <= s_tdata[71:48];
                        gp_reg    <= s_tdata[95:72];
                        gy_reg    <= s_tdata[119:96];
                        dt_reg    <= s_tdata[143:120];
                        seed_reg  <= s_tuser;
                        job_reg   <= JOB_ROLL;
                        state_reg <= ST_VSET;
                    end
                end
                ST_VSET: begin
                    // turn a left half plane vector by a quarter turn first
                    zero_reg <= (vx == 17'sd0) && (vy == 17'sd0);
                    iter_reg <= '0;
                    if (vx < 0) begin
                        if (vy >= 0) begin
                            cx_reg <= 28'(vy) <<< 8;
                            cy_reg <= -(28'(vx) <<< 8);
                            cz_reg <= 21'(Q16_HALF_PI);
                        end else begin
                            cx_reg <= -(28'(vy) <<< 8);
                            cy_reg <= 28'(vx) <<< 8;
                            cz_reg <= -21'(Q16_HALF_PI);
                        end
                    end else begin
                        cx_reg <= 28'(vx) <<< 8;
                        cy_reg <= 28'(vy) <<< 8;
                        cz_reg <= '0;
                    end
                    state_reg <= ST_CORD;
                end
                ST_SSET: begin
                    job_reg   <= JOB_SC;
                    cx_reg    <= 28'(Q24_GAIN);
                    cy_reg    <= '0;
                    cz_reg    <= 21'(sz_fold);
                    neg_reg   <= s_neg;
                    iter_reg  <= '0;
                    state_reg <= ST_CORD;
                end
                ST_CORD: begin
                    cx_reg <= cx_next;
                    cy_reg <= cy_next;
                    cz_reg <= cz_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(NITER - 1)) begin
                        state_reg <= ST_CSTORE;
                    end
                end
                ST_CSTORE: begin
                    unique case (job_reg)
                        JOB_ROLL: begin
                            acc_roll_reg <= zero_reg ? '0 : sat_ang(30'(cz_reg));
                            job_reg      <= JOB_PITCH;
                            state_reg    <= ST_VSET;
                        end
                        JOB_PITCH: begin
                            acc_pitch_reg <= zero_reg ? '0 : sat_ang(30'(cz_reg));
                            step_reg      <= 4'd0;
                            phase_reg     <= 1'b0;
                            state_reg     <= seed_reg ? ST_FIN : ST_MUL;
                            if (seed_reg) begin
                                // seed: load everything from the raw angles
                                filt_roll_reg  <= acc_roll_reg;
                                est_roll_reg   <= acc_roll_reg;
                                filt_pitch_reg <= zero_reg ? '0 : sat_ang(30'(cz_reg));
                                est_pitch_reg  <= zero_reg ? '0 : sat_ang(30'(cz_reg));
                                est_yaw_reg    <= '0;
                            end
                        end
                        default: begin
                            c_reg     <= neg_reg ? 27'(-cx_reg) : 27'(cx_reg);
                            s_reg     <= neg_reg ? 27'(-cy_reg) : 27'(cy_reg);
                            step_reg  <= 4'd4;
                            phase_reg <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                    endcase
                end
                ST_MUL: begin
                    if (!phase_reg) begin
                        prod_reg  <= mul_a * mul_b;
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        step_reg  <= step_reg + 1'b1;
                        unique case (step_reg)
                            4'd0: filt_roll_reg  <= sat_ang(30'(filt_roll_reg) + r16);
                            4'd1: filt_pitch_reg <= sat_ang(30'(filt_pitch_reg) + r16);
                            4'd2: tmp_reg        <= r24;
                            4'd3: begin
                                est_pitch_reg <= sat_ang(30'(est_pitch_reg) + tmp_reg + r24);
                                state_reg     <= ST_SSET;
                            end
                            4'd4: acc_reg  <= prod_reg;
                            4'd5: rate_reg <= rsum_full[26:0];
                            4'd6: tmp_reg  <= r24;
                            4'd7: est_roll_reg <= sat_ang(30'(est_roll_reg) + tmp_reg + r24);
                            4'd8: acc_reg  <= prod_reg;
                            4'd9: rate_reg <= rdiff_full[26:0];
                            default: begin
                                est_yaw_reg <= sat_ang(30'(est_yaw_reg) + r24);
                                state_reg   <= ST_FIN;
                            end
                        endcase
                    end
                end
                default: begin
                    // hold the result until the output register is free
                    if (load_out) begin
                        m_tdata_reg <= {4'b0, filt_pitch_reg, filt_roll_reg,
                                        est_yaw_reg, est_pitch_reg, est_roll_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // the sequencer is busy right after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // the CORDIC step index stays inside the iteration count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (iter_reg < ITER_W'(NITER)))
        else $error("CORDIC step past last iteration");

    // a result leaving the sequencer shows up on the output channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_tvalid && s_tready))
        else $error("finished result not presented");

    // a multiply phase is always followed by its write-back phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && !phase_reg) |=> (state_reg == ST_MUL && phase_reg))
        else $error("multiply phase skipped");

endmodule

// ===== verif/tb_complementary_attitude_filter.sv =====
// Self-checking testbench of the complementary attitude filter.
`timescale 1ns / 1ps

module tb_complementary_attitude_filter;
    import cmpatt_pkg::*;

    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int LONG_HOLD      = 400;

    // One sensor sample as it travels on the input channel.
    typedef struct {
        logic [S_TDATA_W-1:0] data;
        logic                 seed;
    } sample_t;

    // One attitude estimate as it is expected on the result channel.
    typedef struct {
        logic [ANG_W-1:0] roll;
        logic [ANG_W-1:0] pitch;
        logic [ANG_W-1:0] yaw;
        logic [ANG_W-1:0] acc_roll;
        logic [ANG_W-1:0] acc_pitch;
    } attitude_t;

    logic                   aclk;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    sample_t   sample_q[$];
    attitude_t attitude_q[$];

    // Local copy of the filter state and its registers
    longint weight_reg, gain_reg;
    longint lp_roll = 0, lp_pitch = 0, att_roll = 0, att_pitch = 0, att_yaw = 0;

    int     fail_count = 0;
    int     sent_count = 0;
    int     seen_count = 0;
    int     seed_count = 0;
    int     cycle_count = 0;
    int     gap_left;
    int     burst_left;
    int     hold_left;
    bit     hold_req;

    longint atan_tab[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    complementary_attitude_filter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic longint clamp_angle(input longint v);
        if (v > ANG_MAX) return ANG_MAX;
        if (v < ANG_MIN) return ANG_MIN;
        return v;
    endfunction

    // Round to nearest, half up, then floor shift.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q3.16; the zero vector gives zero.
    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, t, dx, dy;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = Q16_HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -Q16_HALF_PI;
            end
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return clamp_angle(z);
    endfunction

    // Rotation CORDIC: cosine and sine in Q.24 of a Q3.16 angle.
    task automatic rotate_unit(input longint a, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = Q24_GAIN;
        y = 0;
        z = a;
        flip = 1'b0;
        while (z > Q16_PI) z -= Q16_TWO_PI;
        while (z < -Q16_PI) z += Q16_TWO_PI;
        if (z > Q16_HALF_PI) begin
            z -= Q16_PI; flip = 1'b1;
        end else if (z < -Q16_HALF_PI) begin
            z += Q16_PI; flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the local filter state by one sample and return the estimate.
    task automatic update_attitude(input sample_t smp, output attitude_t est);
        longint ax, ay, az, gr, gp, gy, dt, raw_roll, raw_pitch, c, s, rate;
        ax = longint'($signed(smp.data[15:0]));
        ay = longint'($signed(smp.data[31:16]));
        az = longint'($signed(smp.data[47:32]));
        gr = longint'($signed(smp.data[71:48]));
        gp = longint'($signed(smp.data[95:72]));
        gy = longint'($signed(smp.data[119:96]));
        dt = longint'(smp.data[143:120]);
        raw_roll  = vector_angle(-ay, -az);
        raw_pitch = vector_angle(ax, -az);
        if (smp.seed) begin
            lp_roll   = raw_roll;
            lp_pitch  = raw_pitch;
            att_roll  = raw_roll;
            att_pitch = raw_pitch;
            att_yaw   = 0;
        end else begin
            lp_roll  = clamp_angle(lp_roll + round_shift(weight_reg * (raw_roll - lp_roll), 16));
            lp_pitch = clamp_angle(lp_pitch
                                   + round_shift(weight_reg * (raw_pitch - lp_pitch), 16));
            att_pitch = clamp_angle(att_pitch + round_shift(gp * dt, 24)
                                    + round_shift(gain_reg * (lp_pitch - att_pitch), 24));
            rotate_unit(att_pitch, c, s);
            rate = round_shift(gr * c + gy * s, 24);
            att_roll = clamp_angle(att_roll + round_shift(rate * dt, 24)
                                   + round_shift(gain_reg * (lp_roll - att_roll), 24));
            rate = round_shift(gy * c - gr * s, 24);
            att_yaw = clamp_angle(att_yaw + round_shift(rate * dt, 24));
        end
        est.roll      = att_roll[ANG_W-1:0];
        est.pitch     = att_pitch[ANG_W-1:0];
        est.yaw       = att_yaw[ANG_W-1:0];
        est.acc_roll  = lp_roll[ANG_W-1:0];
        est.acc_pitch = lp_pitch[ANG_W-1:0];
    endtask

    function automatic sample_t pack_sample(input logic [15:0] ax, input logic [15:0] ay,
                                            input logic [15:0] az, input logic [23:0] gr,
                                            input logic [23:0] gp, input logic [23:0] gy,
                                            input logic [23:0] dt, input logic seed);
        sample_t smp;
        smp.data = {dt, gy, gp, gr, az, ay, ax};
        smp.seed = seed;
        return smp;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        sample_t   smp;
        attitude_t est;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            gap_left   <= 0;
            burst_left <= 8;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered transfer until it is taken
        end else begin
            if (s_tvalid) begin
                smp.data = s_tdata;
                smp.seed = s_tuser;
                update_attitude(smp, est);
                attitude_q.push_back(est);
                sent_count++;
                if (s_tuser) seed_count++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                smp = sample_q.pop_front();
                s_tdata  <= smp.data;
                s_tuser  <= smp.seed;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern picked by bits 9:8 of the cycle counter; one long hold-off on request.
    always @(posedge aclk) begin
        attitude_t est;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_count++;
                if (attitude_q.size() == 0) begin
                    $error("result transfer with no estimate pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    est = attitude_q.pop_front();
                    if (m_tdata[19:0] !== est.roll) begin
                        $error("roll_out expected %h actual %h", est.roll, m_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_tdata[39:20] !== est.pitch) begin
                        $error("pitch_out expected %h actual %h", est.pitch, m_tdata[39:20]);
                        fail_count++;
                    end
                    if (m_tdata[59:40] !== est.yaw) begin
                        $error("yaw_out expected %h actual %h", est.yaw, m_tdata[59:40]);
                        fail_count++;
                    end
                    if (m_tdata[79:60] !== est.acc_roll) begin
                        $error("acc_roll_out expected %h actual %h",
                               est.acc_roll, m_tdata[79:60]);
                        fail_count++;
                    end
                    if (m_tdata[99:80] !== est.acc_pitch) begin
                        $error("acc_pitch_out expected %h actual %h",
                               est.acc_pitch, m_tdata[99:80]);
                        fail_count++;
                    end
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= (hold_left == 1);
            end else begin
                case ((cycle_count >> 8) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Let every queued sample go through, then let the pipeline settle.
    task automatic drain_all();
        while (sample_q.size() > 0 || s_tvalid || attitude_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SMOOTHING_WEIGHT) weight_reg = longint'(v[WEIGHT_W-1:0]);
        else gain_reg = longint'(v[GAIN_W-1:0]);
    endtask

    function automatic logic [15:0] rand_accel();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 10)) - 5);
            2:       return 16'($signed($urandom_range(0, 33000)) - 16500);
            default: return 16'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    function automatic logic [23:0] rand_rate();
        if ($urandom_range(0, 1)) return 24'($signed($urandom_range(0, 524288)) - 262144);
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] rand_step();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);
            1, 2:    return 24'($urandom_range(0, 1 << 20));
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random samples: mostly regular updates, a seed now and then.
    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            sample_q.push_back(pack_sample(rand_accel(), rand_accel(), rand_accel(),
                                           rand_rate(), rand_rate(), rand_rate(),
                                           rand_step(), $urandom_range(0, 19) == 0));
        end
    endtask

    initial begin
        hold_req    = 1'b0;
        weight_reg  = WEIGHT_RESET;
        gain_reg    = GAIN_RESET;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_SMOOTHING_WEIGHT;
        cfg_wdata   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero vector, axis extremes, seeding, zero and full time step,
        // rate extremes and saturation of the integrated angles.
        sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'h0000, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b1));
        sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'h0000, 24'h7FFFFF, 24'h800000,
                                       24'h7FFFFF, 24'h0, 1'b0));
        sample_q.push_back(pack_sample(16'h7FFF, 16'h8000, 16'h8000, 24'h0, 24'h0, 24'h0,
                                       24'h10000, 1'b1));
        sample_q.push_back(pack_sample(16'h8000, 16'h7FFF, 16'h7FFF, 24'h0, 24'h0, 24'h0,
                                       24'h10000, 1'b1));
        sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'h7FFF, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b1));
        sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'h8000, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b1));
        sample_q.push_back(pack_sample(16'h0000, 16'h7FFF, 16'h0000, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b1));
        sample_q.push_back(pack_sample(16'h8000, 16'h0000, 16'h0000, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b1));
        sample_q.push_back(pack_sample(16'h0100, 16'hFF00, 16'hC000, 24'h0, 24'h0, 24'h0,
                                       24'h0, 1'b0));
        for (int k = 0; k < 6; k++)
            sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'hC000, 24'h7FFFFF,
                                           24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b0));
        for (int k = 0; k < 6; k++)
            sample_q.push_back(pack_sample(16'h0000, 16'h0000, 16'hC000, 24'h800000,
                                           24'h800000, 24'h800000, 24'hFFFFFF, 1'b0));
        sample_q.push_back(pack_sample(16'h1234, 16'hEDCB, 16'h4000, 24'h010000, 24'hFF0000,
                                       24'h008000, 24'h000000, 1'b0));
        sample_q.push_back(pack_sample(16'hFFFF, 16'h0001, 16'hFFFF, 24'hAAAAAA, 24'h555555,
                                       24'hAAAAAA, 24'h555555, 1'b0));
        drain_all();

        // Long hold-off on the result side while samples keep coming.
        hold_req = 1'b1;
        queue_random(80);
        repeat (5) @(posedge aclk);
        hold_req = 1'b0;
        drain_all();

        // Register extremes, values with bits above the register width, random
        write_reg(CFG_SMOOTHING_WEIGHT, 24'h000000);
        write_reg(CFG_CORRECTION_GAIN, 24'h000000);
        queue_random(90);
        drain_all();
        write_reg(CFG_SMOOTHING_WEIGHT, 24'hFFFFFF);
        write_reg(CFG_CORRECTION_GAIN, 24'hFFFFFF);
        queue_random(90);
        drain_all();
        write_reg(CFG_SMOOTHING_WEIGHT, CFG_DATA_W'(24'hAB0000 | WEIGHT_RESET));
        write_reg(CFG_CORRECTION_GAIN, CFG_DATA_W'(GAIN_RESET));
        queue_random(150);
        drain_all();
        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_SMOOTHING_WEIGHT, CFG_DATA_W'($urandom));
            write_reg(CFG_CORRECTION_GAIN, CFG_DATA_W'($urandom));
            queue_random(90);
            drain_all();
        end

        $display("Sent %0d samples (%0d seeds), checked %0d estimates over several",
                 sent_count, seed_count, seen_count);
        $display("weight and gain settings, with a long result hold-off and random stalls.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
